@@ rtl/bcd_pkg.sv @@
package bcd_pkg;

    localparam int MAX_DIM_DEF = 4096;
    localparam int DIM_W       = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_TDATA_W  = 152;
    localparam int OUT_TDATA_W = 56;

    localparam logic [1:0] FMT_BC1 = 2'd0;
    localparam logic [1:0] FMT_BC2 = 2'd1;
    localparam logic [1:0] FMT_BC3 = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd4096;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd4096;

    typedef logic [7:0] chan_t;
    // channel 0 red, 1 green, 2 blue
    typedef chan_t [2:0] rgb_t;

    typedef struct packed {
        logic [1:0]        fmt;
        logic              four;
        rgb_t              e0;
        rgb_t              e1;
        chan_t             a0;
        chan_t             a1;
        logic              agt;
        logic [5:0][10:0]  anum7;
        logic [3:0][10:0]  anum5;
        logic [31:0]       cidx;
        logic [63:0]       abits;
        logic [23:0]       base;
        logic [11:0]       row0;
        logic [11:0]       col0;
    } expand_t;

    typedef struct packed {
        logic [1:0]        fmt;
        logic              four;
        rgb_t              e0;
        rgb_t              e1;
        logic [2:0][17:0]  num2;
        logic [2:0][17:0]  num3;
        rgb_t              mean;
        chan_t [7:0]       ramp;
        logic [31:0]       cidx;
        logic [63:0]       abits;
        logic [23:0]       base;
        logic [11:0]       row0;
        logic [11:0]       col0;
    } mix_t;

    typedef struct packed {
        logic [1:0]        fmt;
        logic              four;
        rgb_t [3:0]        pal;
        chan_t [7:0]       ramp;
        logic [31:0]       cidx;
        logic [63:0]       abits;
        logic [23:0]       base;
        logic [11:0]       row0;
        logic [11:0]       col0;
    } block_t;

    typedef struct packed {
        logic       active;
        logic [3:0] cnt;
    } seq_stat_t;

    function automatic chan_t expand5(input logic [4:0] v);
        logic [13:0] t;
        t = 14'(v) * 14'd527 + 14'd23;
        return t[13:6];
    endfunction

    function automatic chan_t expand6(input logic [5:0] v);
        logic [13:0] t;
        t = 14'(v) * 14'd259 + 14'd33;
        return t[13:6];
    endfunction

    // reciprocal multiply, exact for n below 256000
    function automatic chan_t div1000(input logic [17:0] n);
        logic [36:0] p;
        p = 37'(n) * 37'd268436;
        return p[35:28];
    endfunction

    function automatic chan_t div7(input logic [10:0] n);
        logic [22:0] p;
        p = 23'(n) * 23'd2341;
        return p[21:14];
    endfunction

    function automatic chan_t div5(input logic [10:0] n);
        logic [22:0] p;
        p = 23'(n) * 23'd3277;
        return p[21:14];
    endfunction

endpackage

@@ rtl/bcd_expand.sv @@
module bcd_expand (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [1:0]                fmt,
    input  logic [bcd_pkg::DIM_W-1:0] img_w,
    input  logic                      up_valid,
    output logic                      up_ready,
    input  logic [63:0]               first_half,
    input  logic [63:0]               second_half,
    input  logic [9:0]                block_row,
    input  logic [9:0]                block_col,
    output logic                      dn_valid,
    input  logic                      dn_ready,
    output bcd_pkg::expand_t          dn_data
);
    import bcd_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    logic        load;
    expand_t     data_reg;
    expand_t     data_next;
    logic [63:0] colour;
    logic [15:0] raw0;
    logic [15:0] raw1;
    logic [24:0] row_prod;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    assign colour   = (fmt == FMT_BC1) ? first_half : second_half;
    assign raw0     = colour[15:0];
    assign raw1     = colour[31:16];
    assign row_prod = 25'({block_row, 2'b00}) * 25'(img_w);

    always_comb
    begin
        data_next.fmt   = fmt;
        data_next.four  = (fmt != FMT_BC1) || (raw0 > raw1);
        data_next.e0[0] = expand5(raw0[15:11]);
        data_next.e0[1] = expand6(raw0[10:5]);
        data_next.e0[2] = expand5(raw0[4:0]);
        data_next.e1[0] = expand5(raw1[15:11]);
        data_next.e1[1] = expand6(raw1[10:5]);
        data_next.e1[2] = expand5(raw1[4:0]);
        data_next.a0    = first_half[7:0];
        data_next.a1    = first_half[15:8];
        data_next.agt   = first_half[7:0] > first_half[15:8];
        for (int k = 1; k <= 6; k++)
        begin
            data_next.anum7[k-1] = 11'(7 - k) * 11'(first_half[7:0])
                                 + 11'(k) * 11'(first_half[15:8]);
        end
        for (int k = 1; k <= 4; k++)
        begin
            data_next.anum5[k-1] = 11'(5 - k) * 11'(first_half[7:0])
                                 + 11'(k) * 11'(first_half[15:8]);
        end
        data_next.cidx  = colour[63:32];
        data_next.abits = first_half;
        data_next.base  = row_prod[23:0] + 24'({block_col, 2'b00});
        data_next.row0  = {block_row, 2'b00};
        data_next.col0  = {block_col, 2'b00};
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (dn_ready)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

endmodule

@@ rtl/bcd_mix.sv @@
module bcd_mix (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             up_valid,
    output logic             up_ready,
    input  bcd_pkg::expand_t up_data,
    output logic             dn_valid,
    input  logic             dn_ready,
    output bcd_pkg::mix_t    dn_data
);
    import bcd_pkg::*;

    logic valid_reg;
    logic valid_next;
    logic load;
    mix_t data_reg;
    mix_t data_next;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_comb
    begin
        data_next.fmt  = up_data.fmt;
        data_next.four = up_data.four;
        data_next.e0   = up_data.e0;
        data_next.e1   = up_data.e1;
        for (int ch = 0; ch < 3; ch++)
        begin
            data_next.num2[ch] = 18'(up_data.e0[ch]) * 18'd667
                               + 18'(up_data.e1[ch]) * 18'd333;
            data_next.num3[ch] = 18'(up_data.e0[ch]) * 18'd333
                               + 18'(up_data.e1[ch]) * 18'd667;
            data_next.mean[ch] = 8'((9'(up_data.e0[ch]) + 9'(up_data.e1[ch])) >> 1);
        end
        data_next.ramp[0] = up_data.a0;
        data_next.ramp[1] = up_data.a1;
        if (up_data.agt)
        begin
            for (int k = 1; k <= 6; k++)
            begin
                data_next.ramp[k+1] = div7(up_data.anum7[k-1]);
            end
        end
        else
        begin
            for (int k = 1; k <= 4; k++)
            begin
                data_next.ramp[k+1] = div5(up_data.anum5[k-1]);
            end
            data_next.ramp[6] = 8'd0;
            data_next.ramp[7] = 8'd255;
        end
        data_next.cidx  = up_data.cidx;
        data_next.abits = up_data.abits;
        data_next.base  = up_data.base;
        data_next.row0  = up_data.row0;
        data_next.col0  = up_data.col0;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (dn_ready)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

endmodule

@@ rtl/bcd_palette.sv @@
module bcd_palette (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    output logic            up_ready,
    input  bcd_pkg::mix_t   up_data,
    output logic            dn_valid,
    input  logic            dn_ready,
    output bcd_pkg::block_t dn_data
);
    import bcd_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    logic   load;
    block_t data_reg;
    block_t data_next;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_comb
    begin
        data_next.fmt    = up_data.fmt;
        data_next.four   = up_data.four;
        data_next.pal[0] = up_data.e0;
        data_next.pal[1] = up_data.e1;
        for (int ch = 0; ch < 3; ch++)
        begin
            if (up_data.four)
            begin
                data_next.pal[2][ch] = div1000(up_data.num2[ch]);
                data_next.pal[3][ch] = div1000(up_data.num3[ch]);
            end
            else
            begin
                // three-colour mode: mean and black
                data_next.pal[2][ch] = up_data.mean[ch];
                data_next.pal[3][ch] = 8'd0;
            end
        end
        data_next.ramp  = up_data.ramp;
        data_next.cidx  = up_data.cidx;
        data_next.abits = up_data.abits;
        data_next.base  = up_data.base;
        data_next.row0  = up_data.row0;
        data_next.col0  = up_data.col0;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (dn_ready)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

endmodule

@@ rtl/bcd_pixel_seq.sv @@
module bcd_pixel_seq (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [bcd_pkg::DIM_W-1:0]       img_w,
    input  logic [bcd_pkg::DIM_W-1:0]       img_h,
    input  logic                            blk_valid,
    output logic                            blk_ready,
    input  bcd_pkg::block_t                 blk,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bcd_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                            m_tuser,
    output logic                            m_tlast,
    output bcd_pkg::seq_stat_t              stat
);
    import bcd_pkg::*;

    logic                   pix_last;
    logic [3:0]             pix_reg;
    logic [3:0]             pix_next;
    logic [23:0]            row_idx_reg;
    logic [23:0]            row_idx_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                   out_user_reg;
    logic                   out_last_reg;
    logic                   emit;
    logic [1:0]             px;
    logic [1:0]             py;
    logic [23:0]            cur_row;
    logic [23:0]            pix_index;
    logic [11:0]            row;
    logic [11:0]            col;
    logic                   in_image;
    logic [15:0][1:0]       ci_arr;
    logic [15:0][3:0]       nib_arr;
    logic [15:0][2:0]       aix_arr;
    logic [1:0]             ci;
    rgb_t                   rgb;
    chan_t                  alpha;

    assign pix_last  = pix_reg == 4'd15;
    assign emit      = blk_valid && (!out_valid_reg || m_tready);
    assign blk_ready = emit && pix_last;

    assign px = pix_reg[1:0];
    assign py = pix_reg[3:2];

    assign cur_row   = (py == 2'd0) ? blk.base : row_idx_reg;
    assign pix_index = cur_row + 24'(px);
    assign row       = blk.row0 + 12'(py);
    assign col       = blk.col0 + 12'(px);
    assign in_image  = (13'(col) < img_w) && (13'(row) < img_h);

    assign ci_arr  = blk.cidx;
    assign nib_arr = blk.abits;
    assign aix_arr = blk.abits[63:16];
    assign ci      = ci_arr[pix_reg];
    assign rgb     = blk.pal[ci];

    always_comb
    begin
        unique case (blk.fmt)
            FMT_BC1:
            begin
                alpha = (!blk.four && ci == 2'd3) ? 8'd0 : 8'd255;
            end
            FMT_BC2:
            begin
                alpha = {nib_arr[pix_reg], nib_arr[pix_reg]};
            end
            default:
            begin
                alpha = blk.ramp[aix_arr[pix_reg]];
            end
        endcase
    end

    always_comb
    begin
        pix_next     = pix_reg;
        row_idx_next = row_idx_reg;
        if (emit)
        begin
            pix_next = pix_reg + 4'd1;
            if (px == 2'd3)
            begin
                row_idx_next = cur_row + 24'(img_w);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pix_reg       <= pix_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_idx_reg <= row_idx_next;
        if (emit)
        begin
            out_data_reg <= {pix_index, alpha, rgb[2], rgb[1], rgb[0]};
            out_user_reg <= in_image;
            out_last_reg <= pix_last;
        end
    end

    assign m_tvalid    = out_valid_reg;
    assign m_tdata     = out_data_reg;
    assign m_tuser     = out_user_reg;
    assign m_tlast     = out_last_reg;
    assign stat.active = blk_valid;
    assign stat.cnt    = pix_reg;

endmodule

@@ rtl/bc_texture_block_decoder_core.sv @@
// Decodes one 4x4 BC1/BC2/BC3 compressed block per request into sixteen RGBA8
// pixels, emitted in raster order one per cycle while the output is not
// stalled, with the image index and an inside-image flag per pixel and tlast
// on the sixteenth. A block passes an input register and three decode
// registers (endpoint expand, blend numerators, palette divide) before the
// pixel sequencer and its output register, and the pipeline loads the next
// blocks while the current one is still being sent. Throughput is bound by
// the single-pixel output register fed by the 16-step pixel counter. The user
// must write format, width and height through the register port only while no
// block is in flight; the block itself does not enforce this. Width and height
// above MAX_DIM are clamped to MAX_DIM.
module bc_texture_block_decoder_core #(
    parameter int MAX_DIM = bcd_pkg::MAX_DIM_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [bcd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bcd_pkg::DIM_W-1:0]       cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // first_half, second_half, block_row, block_col, zero pad
    input  logic [bcd_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // red, green, blue, alpha, pixel_index
    output logic [bcd_pkg::OUT_TDATA_W-1:0] m_tdata,
    // inside_res
    output logic                            m_tuser,
    output logic                            m_tlast
);
    import bcd_pkg::*;

    localparam logic [DIM_W-1:0] DIM_CLAMP = DIM_W'(MAX_DIM);

    logic [1:0]       fmt_reg;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [DIM_W-1:0] img_w;
    logic [DIM_W-1:0] img_h;

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [63:0] first_reg;
    logic [63:0] second_reg;
    logic [9:0]  row_reg;
    logic [9:0]  col_reg;
    logic        in_load;

    logic      exp_ready;
    logic      exp_valid;
    expand_t   exp_data;
    logic      mix_ready;
    logic      mix_valid;
    mix_t      mix_data;
    logic      pal_ready;
    logic      pal_valid;
    block_t    pal_data;
    seq_stat_t stat;

    assign img_w = (int'(width_reg) > MAX_DIM) ? DIM_CLAMP : width_reg;
    assign img_h = (int'(height_reg) > MAX_DIM) ? DIM_CLAMP : height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg    <= FMT_BC1;
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_BLOCK_FORMAT: fmt_reg    <= cfg_data[1:0];
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign s_tready = !in_valid_reg || exp_ready;
    assign in_load  = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (exp_ready)
        begin
            in_valid_next = 1'b0;
        end
        if (in_load)
        begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            first_reg  <= s_tdata[63:0];
            second_reg <= s_tdata[127:64];
            row_reg    <= s_tdata[137:128];
            col_reg    <= s_tdata[147:138];
        end
    end

    bcd_expand u_expand (
        .clk         (clk),
        .rst_n       (rst_n),
        .fmt         (fmt_reg),
        .img_w       (img_w),
        .up_valid    (in_valid_reg),
        .up_ready    (exp_ready),
        .first_half  (first_reg),
        .second_half (second_reg),
        .block_row   (row_reg),
        .block_col   (col_reg),
        .dn_valid    (exp_valid),
        .dn_ready    (mix_ready),
        .dn_data     (exp_data)
    );

    bcd_mix u_mix (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (exp_valid),
        .up_ready (mix_ready),
        .up_data  (exp_data),
        .dn_valid (mix_valid),
        .dn_ready (pal_ready),
        .dn_data  (mix_data)
    );

    logic seq_ready;

    bcd_palette u_palette (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (mix_valid),
        .up_ready (pal_ready),
        .up_data  (mix_data),
        .dn_valid (pal_valid),
        .dn_ready (seq_ready),
        .dn_data  (pal_data)
    );

    bcd_pixel_seq u_pixel_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .img_w     (img_w),
        .img_h     (img_h),
        .blk_valid (pal_valid),
        .blk_ready (seq_ready),
        .blk       (pal_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .stat      (stat)
    );

    // pixel counter only runs mid-block while a decoded block is held
    a_cnt_needs_block: assert property (@(posedge clk) disable iff (!rst_n)
        stat.cnt != 4'd0 |-> stat.active)
        else $error("pixel counter mid-block without a decoded block");

    // a pending last pixel means the counter has wrapped to the next block
    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> stat.cnt == 4'd0)
        else $error("last pixel pending but counter not wrapped");

    // a pending inner pixel keeps its block in the palette register
    a_inner_holds_block: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> stat.active && stat.cnt != 4'd0)
        else $error("inner pixel pending but block released");

endmodule

@@ tb/sv/tb_bc_texture_block_decoder_core.sv @@
module tb_bc_texture_block_decoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    import bcd_pkg::*;

    localparam int unsigned MAX_DIM       = MAX_DIM_DEF;
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned HOLD_CYCLES   = 240;
    localparam int unsigned TAIL_CYCLES   = 40;
    localparam int          DIR_ROWS      = 18;
    localparam int          PHASES        = 6;
    localparam int          PHASE_ITEMS   = 60;
    localparam logic [1:0]  FMT_ALIAS_BC3 = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [23:0] pixel_index;
        logic        in_image;
        logic        last;
    } pixel_t;

    typedef struct packed {
        logic [1:0]  fmt;
        logic [12:0] width;
        logic [12:0] height;
        logic [63:0] first_half;
        logic [63:0] second_half;
        logic [9:0]  brow;
        logic [9:0]  bcol;
        logic        pinned;
        pixel_t      px0;
    } dir_row_t;

    localparam pixel_t NO_PIN = '0;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [DIM_W-1:0]       cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;

    // mirror of the block's registers
    logic [1:0]  fmt_reg    = FMT_BC1;
    logic [12:0] width_reg  = WIDTH_RST;
    logic [12:0] height_reg = HEIGHT_RST;

    pixel_t pixel_q [$];
    pixel_t want_px;
    int unsigned errors = 0;
    bit steady  = 1'b0;
    bit hold_go = 1'b0;

    dir_row_t dir_rows [DIR_ROWS] = '{
        // reset settings, all-zero block
        '{FMT_BC1, 13'd4096, 13'd4096, 64'h0, 64'h0, 10'd0, 10'd0,
          1'b1, '{8'd0, 8'd0, 8'd0, 8'd255, 24'd0, 1'b1, 1'b0}},
        // all ones: three-colour mode, transparent black, far corner
        '{FMT_BC1, 13'd4096, 13'd4096, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 10'd1023, 10'd1023,
          1'b1, '{8'd0, 8'd0, 8'd0, 8'd0, 24'd16764924, 1'b1, 1'b0}},
        // white over black, four-colour mode
        '{FMT_BC1, 13'd4096, 13'd4096, 64'h0000_0000_0000_FFFF, 64'h0, 10'd0, 10'd5,
          1'b1, '{8'd255, 8'd255, 8'd255, 8'd255, 24'd20, 1'b1, 1'b0}},
        '{FMT_BC1, 13'd4096, 13'd4096, 64'h1B4E_E4B1_07E0_F81F, 64'hDEAD_BEEF_0BAD_F00D,
          10'd3, 10'd2, 1'b0, NO_PIN},
        '{FMT_BC1, 13'd4096, 13'd4096, 64'hE4E4_1B1B_F800_1234, 64'h0, 10'd7, 10'd9,
          1'b0, NO_PIN},
        // equal colour endpoints
        '{FMT_BC1, 13'd4096, 13'd4096, 64'h55AA_55AA_8410_8410, 64'h0, 10'd11, 10'd4,
          1'b0, NO_PIN},
        '{FMT_BC2, 13'd4096, 13'd4096, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 10'd5, 10'd7,
          1'b1, '{8'd0, 8'd0, 8'd0, 8'd255, 24'd81948, 1'b1, 1'b0}},
        '{FMT_BC2, 13'd4096, 13'd4096, 64'hFEDC_BA98_7654_3210, 64'h9C63_27D8_001F_FFE0,
          10'd2, 10'd8, 1'b0, NO_PIN},
        // colour0 below colour1 still decodes four-colour outside bc1
        '{FMT_BC3, 13'd4096, 13'd4096, 64'h5A3C_96E1_4D2B_00FF, 64'h4E1B_D2A7_F81F_07E0,
          10'd6, 10'd1, 1'b0, NO_PIN},
        // equal alpha endpoints, six-value ramp, code six gives zero
        '{FMT_BC3, 13'd4096, 13'd4096, 64'hFAC6_88D5_8E3E_8080, 64'h0, 10'd0, 10'd0,
          1'b1, '{8'd0, 8'd0, 8'd0, 8'd0, 24'd0, 1'b1, 1'b0}},
        // six-value ramp, code seven gives opaque
        '{FMT_BC3, 13'd4096, 13'd4096, 64'h0000_0000_0007_F010, 64'h0, 10'd0, 10'd1,
          1'b1, '{8'd0, 8'd0, 8'd0, 8'd255, 24'd4, 1'b1, 1'b0}},
        '{FMT_BC3, 13'd4096, 13'd4096, 64'hB6DB_6DB6_DB6D_40C0, 64'h3C5A_96E1_F81F_FFE0,
          10'd9, 10'd12, 1'b0, NO_PIN},
        '{FMT_ALIAS_BC3, 13'd4096, 13'd4096, 64'h9249_2492_4924_C040, 64'h0123_4567_89AB_CDEF,
          10'd4, 10'd4, 1'b0, NO_PIN},
        '{FMT_BC1, 13'd1, 13'd1, 64'hA5A5_A5A5_F0F0_0F0F, 64'h0, 10'd0, 10'd0,
          1'b0, NO_PIN},
        // zero size: nothing inside
        '{FMT_BC1, 13'd0, 13'd0, 64'h0, 64'h0, 10'd2, 10'd3,
          1'b1, '{8'd0, 8'd0, 8'd0, 8'd255, 24'd12, 1'b0, 1'b0}},
        // oversize registers clamp
        '{FMT_BC1, 13'd8191, 13'd8191, 64'h0, 64'h0, 10'd1023, 10'd1023,
          1'b1, '{8'd0, 8'd0, 8'd0, 8'd255, 24'd16764924, 1'b1, 1'b0}},
        '{FMT_BC2, 13'd7, 13'd5, 64'h0F1E_2D3C_4B5A_6978, 64'h8877_6655_4433_2211,
          10'd1, 10'd1, 1'b0, NO_PIN},
        '{FMT_BC3, 13'd4097, 13'd4, 64'h7E81_3C5A_A55A_3377, 64'hC3A5_5A3C_1234_ABCD,
          10'd0, 10'd1023, 1'b0, NO_PIN}
    };

    bc_texture_block_decoder_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int unsigned widen5(input logic [4:0] v);
        return (32'(v) * 527 + 23) >> 6;
    endfunction

    function automatic int unsigned widen6(input logic [5:0] v);
        return (32'(v) * 259 + 33) >> 6;
    endfunction

    // decode one block under the mirrored registers and queue its sixteen pixels
    task automatic expect_block(input logic [63:0] first_half, input logic [63:0] second_half,
                                input logic [9:0] brow, input logic [9:0] bcol,
                                input bit pinned, input pixel_t px0);
        logic [63:0] colour;
        int unsigned w, h, ci, row, col, a0, a1;
        int unsigned e0 [3];
        int unsigned e1 [3];
        int unsigned pal [4][3];
        int unsigned ramp [8];
        bit four;
        pixel_t px;
        w = (width_reg > MAX_DIM) ? MAX_DIM : width_reg;
        h = (height_reg > MAX_DIM) ? MAX_DIM : height_reg;
        colour = (fmt_reg == FMT_BC1) ? first_half : second_half;
        four = (fmt_reg != FMT_BC1) || (colour[15:0] > colour[31:16]);
        e0[0] = widen5(colour[15:11]);
        e0[1] = widen6(colour[10:5]);
        e0[2] = widen5(colour[4:0]);
        e1[0] = widen5(colour[31:27]);
        e1[1] = widen6(colour[26:21]);
        e1[2] = widen5(colour[20:16]);
        for (int c = 0; c < 3; c++)
        begin
            pal[0][c] = e0[c];
            pal[1][c] = e1[c];
            if (four)
            begin
                pal[2][c] = (667 * e0[c] + 333 * e1[c]) / 1000;
                pal[3][c] = (333 * e0[c] + 667 * e1[c]) / 1000;
            end
            else
            begin
                pal[2][c] = (e0[c] + e1[c]) >> 1;
                pal[3][c] = 0;
            end
        end
        a0 = 32'(first_half[7:0]);
        a1 = 32'(first_half[15:8]);
        ramp[0] = a0;
        ramp[1] = a1;
        if (a0 > a1)
        begin
            for (int k = 1; k <= 6; k++)
                ramp[k + 1] = ((7 - k) * a0 + k * a1) / 7;
        end
        else
        begin
            for (int k = 1; k <= 4; k++)
                ramp[k + 1] = ((5 - k) * a0 + k * a1) / 5;
            ramp[6] = 0;
            ramp[7] = 255;
        end
        for (int i = 0; i < 16; i++)
        begin
            ci  = 32'((colour >> (32 + 2 * i)) & 64'd3);
            row = 32'(brow) * 4 + i / 4;
            col = 32'(bcol) * 4 + i % 4;
            px.red   = 8'(pal[ci][0]);
            px.green = 8'(pal[ci][1]);
            px.blue  = 8'(pal[ci][2]);
            case (fmt_reg)
                FMT_BC1: px.alpha = (!four && ci == 3) ? 8'd0 : 8'd255;
                FMT_BC2: px.alpha = 8'(((first_half >> (4 * i)) & 64'hF) * 17);
                default: px.alpha = 8'(ramp[3'((first_half >> (16 + 3 * i)) & 64'h7)]);
            endcase
            px.pixel_index = 24'(row * w + col);
            px.in_image    = (col < w) && (row < h);
            px.last        = (i == 15);
            if (i == 0 && pinned)
            begin
                px      = px0;
                px.last = 1'b0;
            end
            pixel_q.push_back(px);
        end
    endtask

    task automatic send_block(input logic [63:0] first_half, input logic [63:0] second_half,
                              input logic [9:0] brow, input logic [9:0] bcol,
                              input bit pinned, input pixel_t px0);
        if (!steady && $urandom_range(99) < 25)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, bcol, brow, second_half, first_half};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        expect_block(first_half, second_half, brow, bcol, pinned, px0);
    endtask

    // drain, then rewrite all three registers
    task automatic apply_setup(input logic [1:0] fmt, input logic [12:0] width,
                               input logic [12:0] height);
        s_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_BLOCK_FORMAT;
        cfg_data  <= DIM_W'(fmt);
        @(posedge clk);
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= width;
        @(posedge clk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data  <= height;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        fmt_reg    = fmt;
        width_reg  = width;
        height_reg = height;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pixel_q.size() == 0)
            begin
                $error("pixel out with no request pending: tdata %h", m_tdata);
                errors++;
            end
            else
            begin
                want_px = pixel_q.pop_front();
                check_field("red", 32'(want_px.red), 32'(m_tdata[7:0]));
                check_field("green", 32'(want_px.green), 32'(m_tdata[15:8]));
                check_field("blue", 32'(want_px.blue), 32'(m_tdata[23:16]));
                check_field("alpha", 32'(want_px.alpha), 32'(m_tdata[31:24]));
                check_field("pixel_index", 32'(want_px.pixel_index), 32'(m_tdata[55:32]));
                check_field("inside_res", 32'(want_px.in_image), 32'(m_tuser));
                check_field("last", 32'(want_px.last), 32'(m_tlast));
            end
        end
    end

    // output side: random stalls, one long hold-off on request
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_go)
            begin
                hold_go   = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= steady || ($urandom_range(99) >= 6);
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("** bc_texture_block_decoder_core: FAILED **");
        $finish;
    end

    initial
    begin
        logic [63:0] first_half, second_half;
        logic [9:0]  brow, bcol;
        int unsigned w_eff, h_eff, row_span, col_span;
        int          item;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // write to the unused index must leave the registers alone
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_SPARE;
        cfg_data  <= '1;
        @(posedge clk);
        cfg_wr_en <= 1'b0;

        foreach (dir_rows[r])
        begin
            if (dir_rows[r].fmt != fmt_reg || dir_rows[r].width != width_reg ||
                dir_rows[r].height != height_reg)
                apply_setup(dir_rows[r].fmt, dir_rows[r].width, dir_rows[r].height);
            send_block(dir_rows[r].first_half, dir_rows[r].second_half, dir_rows[r].brow,
                       dir_rows[r].bcol, dir_rows[r].pinned, dir_rows[r].px0);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: apply_setup(FMT_BC1, 13'd4096, 13'd4096);
                1: apply_setup(FMT_BC2, 13'd640, 13'd480);
                2: apply_setup(FMT_BC3, 13'd8191, 13'd8191);
                3: apply_setup(FMT_ALIAS_BC3, 13'd13, 13'd9);
                4: apply_setup(FMT_BC1, 13'd1, 13'd4096);
                default: apply_setup(2'($urandom_range(0, 3)), 13'($urandom_range(0, 8191)),
                                     13'($urandom_range(0, 8191)));
            endcase
            w_eff = (width_reg > MAX_DIM) ? MAX_DIM : width_reg;
            h_eff = (height_reg > MAX_DIM) ? MAX_DIM : height_reg;
            col_span = (w_eff == 0) ? 0 : (w_eff - 1) / 4;
            row_span = (h_eff == 0) ? 0 : (h_eff - 1) / 4;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                item = ph * PHASE_ITEMS + n;
                steady = (item >= 200 && item < 280);
                if (item == 90)
                    hold_go = 1'b1;
                first_half  = {$urandom, $urandom};
                second_half = {$urandom, $urandom};
                // equal endpoints now and then
                if ($urandom_range(7) == 0)
                begin
                    if (fmt_reg == FMT_BC1)
                        first_half[31:16] = first_half[15:0];
                    else
                        second_half[31:16] = second_half[15:0];
                end
                if (fmt_reg != FMT_BC1 && $urandom_range(7) == 0)
                    first_half[15:8] = first_half[7:0];
                // mostly blocks that touch the image, the rest anywhere
                if ($urandom_range(9) < 7)
                begin
                    brow = 10'($urandom_range(0, row_span));
                    bcol = 10'($urandom_range(0, col_span));
                end
                else
                begin
                    brow = 10'($urandom_range(0, 1023));
                    bcol = 10'($urandom_range(0, 1023));
                end
                send_block(first_half, second_half, brow, bcol, 1'b0, NO_PIN);
            end
        end
        steady = 1'b0;

        s_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("** bc_texture_block_decoder_core: PASSED **");
        else
            $display("** bc_texture_block_decoder_core: FAILED **");
        $finish;
    end

endmodule
